### hw/rtl/mlpcr_pkg.sv
// mlpcr_pkg: shared constants, codes and types of the clamped relu mlp inference unit
// no dependencies; used by the interfaces, the mac datapath and the top level

package mlpcr_pkg;

	// network geometry
	localparam int MAX_LAYERS = 6;
	localparam int MAX_WIDTH  = 16;
	localparam int VALUE_BITS = 16;

	// field and index widths
	localparam int CMD_W  = 2;
	localparam int LSEL_W = 3;
	localparam int NIDX_W = $clog2(MAX_WIDTH);
	localparam int SIZE_W = 5;
	localparam int LCNT_W = 3;
	localparam int THR_W  = 14;

	// fixed point and accumulator
	localparam int FRAC_BITS = 13;
	localparam int ACT_W     = FRAC_BITS + 1;
	localparam int PROD_W    = 2 * VALUE_BITS;
	localparam int ACC_W     = 40;

	// stores
	localparam int W_DEPTH  = (MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH;
	localparam int B_DEPTH  = (MAX_LAYERS - 1) * MAX_WIDTH;
	localparam int W_ADDR_W = $clog2(W_DEPTH);
	localparam int B_ADDR_W = $clog2(B_DEPTH);

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 14;

	// command codes
	localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BIAS   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INPUT  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RUN    = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_FIRST  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_LAST   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 4'd7;

	// reset values
	localparam logic [LCNT_W-1:0] LCNT_RESET = 3'd3;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
	localparam logic [THR_W-1:0]  THR_RESET  = 14'd4096;

	// mac datapath controls
	typedef struct packed {
		logic mul_weight;
		logic load_bias;
		logic acc_clr;
		logic acc_add;
	} mac_ctrl_t;

endpackage

### hw/rtl/mlpcr_if.sv
// mlpcr_if: valid/ready channels of the mlp inference unit (command, result, config)
// depends on mlpcr_pkg for field widths

interface mlpcr_cmd_if;
	logic                                  valid;
	logic                                  ready;
	logic [mlpcr_pkg::CMD_W-1:0]           command;
	logic [mlpcr_pkg::LSEL_W-1:0]          layer_sel;
	logic [mlpcr_pkg::NIDX_W-1:0]          dest_neuron;
	logic [mlpcr_pkg::NIDX_W-1:0]          src_neuron;
	logic signed [mlpcr_pkg::VALUE_BITS-1:0] data_value;

	modport source (output valid, command, layer_sel, dest_neuron, src_neuron, data_value,
		input ready);
	modport sink (input valid, command, layer_sel, dest_neuron, src_neuron, data_value,
		output ready);
endinterface

interface mlpcr_res_if;
	logic                          valid;
	logic                          ready;
	logic [mlpcr_pkg::NIDX_W-1:0]  out_index;
	logic                          out_bit;
	logic                          last;

	modport source (output valid, out_index, out_bit, last, input ready);
	modport sink (input valid, out_index, out_bit, last, output ready);
endinterface

interface mlpcr_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mlpcr_pkg::CFG_IDX_W-1:0]   reg_index;
	logic [mlpcr_pkg::CFG_DATA_W-1:0]  wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

### hw/rtl/mlp_clamped_relu_inference_unit.sv
// mlp_clamped_relu_inference_unit: fully connected network, q2.13, relu clamped at one
// depends on mlpcr_pkg, mlpcr_if, mlpcr_ram and mlpcr_mac
//
// channel  dir  handshake      payload
// cmd      in   valid/ready    command, layer_sel, dest_neuron, src_neuron, data_value
// res      out  valid/ready    out_index, out_bit, last
// cfg      in   valid/ready    reg_index, wdata (ready always high)
//
// a load item (weight, bias, input neuron) leaves the unit idle; loads can follow back to back
// a run steps each layer through the shared mac, then passes one output neuron per
// cycle into the result register while it is free; cmd.ready is low for the whole run
// the mac loop steps through weight ram read, multiply and accumulate for each weight
// the result register holds a stalled item and the run waits on it
// reset sets config defaults, clears inputs and control; the weight and bias rams are not cleared

module mlp_clamped_relu_inference_unit (
	input logic           clk,
	input logic           arst_n,
	mlpcr_cmd_if.sink     cmd,
	mlpcr_res_if.source   res,
	mlpcr_cfg_if.sink     cfg
);

	localparam int VB  = mlpcr_pkg::VALUE_BITS;
	localparam int NW  = mlpcr_pkg::NIDX_W;
	localparam int LW  = mlpcr_pkg::LSEL_W;
	localparam int SW  = mlpcr_pkg::SIZE_W;
	localparam int AW  = mlpcr_pkg::ACT_W;
	localparam int MW  = mlpcr_pkg::MAX_WIDTH;
	localparam int ML  = mlpcr_pkg::MAX_LAYERS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_W_RD,
		ST_W_MUL,
		ST_W_ACC,
		ST_B_LD,
		ST_B_ACC,
		ST_ACT,
		ST_EMIT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [mlpcr_pkg::LCNT_W-1:0] lcnt_q;
	logic [SW-1:0]                size_q [ML];
	logic [mlpcr_pkg::THR_W-1:0]  thr_q;

	// neuron buffers: input layer and two activation banks
	logic signed [VB-1:0] in_q  [MW];
	logic [AW-1:0]        act_q [2*MW];

	// sequencer counters
	logic [LW-1:0] l_q;
	logic [NW-1:0] d_q;
	logic [NW-1:0] s_q;

	// result register
	logic          res_valid_q;
	logic [NW-1:0] res_index_q;
	logic          res_bit_q;
	logic          res_last_q;

	logic                    cmd_acc;
	logic [LW-1:0]           nl_m2;
	logic [SW-1:0]           ns;
	logic [SW-1:0]           nd;
	logic                    s_last;
	logic                    d_last;
	logic                    l_last;
	logic                    res_free;
	logic [NW:0]             act_raddr;
	logic [AW-1:0]           act_rd;
	logic signed [VB-1:0]    operand;
	logic [AW-1:0]           act_new;
	logic                    w_we;
	logic                    b_we;
	logic [VB-1:0]           w_rdata;
	logic [VB-1:0]           b_rdata;
	mlpcr_pkg::mac_ctrl_t    mac_ctrl;

	function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] sz);
		if (sz == '0) begin
			return SW'(1);
		end else if (sz > SW'(MW)) begin
			return SW'(MW);
		end
		return sz;
	endfunction

	assign cmd.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign cmd_acc   = cmd.valid && cmd.ready;

	assign res.valid     = res_valid_q;
	assign res.out_index = res_index_q;
	assign res.out_bit   = res_bit_q;
	assign res.last      = res_last_q;

	// effective layer count minus two, and sizes of the current layer pair
	always_comb begin
		if (lcnt_q < mlpcr_pkg::LCNT_W'(2)) begin
			nl_m2 = '0;
		end else if (lcnt_q > mlpcr_pkg::LCNT_W'(ML)) begin
			nl_m2 = LW'(ML - 2);
		end else begin
			nl_m2 = LW'(lcnt_q - mlpcr_pkg::LCNT_W'(2));
		end
	end

	assign ns     = eff_size(size_q[l_q]);
	assign nd     = eff_size(size_q[l_q + LW'(1)]);
	assign s_last = ((SW'(s_q) + SW'(1)) == ns);
	assign d_last = ((SW'(d_q) + SW'(1)) == nd);
	assign l_last = (l_q == nl_m2);
	assign res_free = !res_valid_q || res.ready;

	// layer l reads bank ~l[0] and writes bank l[0]; emit reads the bank just written
	assign act_raddr = (state_q == ST_EMIT) ? {l_q[0], d_q} : {~l_q[0], s_q};
	assign act_rd    = act_q[act_raddr];
	assign operand   = (l_q == '0) ? in_q[s_q] : VB'(act_rd);

	// store writes from load items
	assign w_we = cmd_acc && (cmd.command == mlpcr_pkg::CMD_WEIGHT)
		&& (cmd.layer_sel < LW'(ML - 1));
	assign b_we = cmd_acc && (cmd.command == mlpcr_pkg::CMD_BIAS)
		&& (cmd.layer_sel < LW'(ML - 1));

	mlpcr_ram #(
		.WIDTH(VB),
		.DEPTH(mlpcr_pkg::W_DEPTH)
	) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (mlpcr_pkg::W_ADDR_W'({cmd.layer_sel, cmd.dest_neuron, cmd.src_neuron})),
		.wdata (cmd.data_value),
		.raddr (mlpcr_pkg::W_ADDR_W'({l_q, d_q, s_q})),
		.rdata (w_rdata)
	);

	mlpcr_ram #(
		.WIDTH(VB),
		.DEPTH(mlpcr_pkg::B_DEPTH)
	) u_bias_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (mlpcr_pkg::B_ADDR_W'({cmd.layer_sel, cmd.dest_neuron})),
		.wdata (cmd.data_value),
		.raddr (mlpcr_pkg::B_ADDR_W'({l_q, d_q})),
		.rdata (b_rdata)
	);

	// mac controls from the sequencer state
	always_comb begin
		mac_ctrl.mul_weight = (state_q == ST_W_MUL);
		mac_ctrl.load_bias  = (state_q == ST_B_LD);
		mac_ctrl.acc_clr    = (state_q == ST_IDLE) || (state_q == ST_ACT);
		mac_ctrl.acc_add    = (state_q == ST_W_ACC) || (state_q == ST_B_ACC);
	end

	mlpcr_mac u_mac (
		.clk     (clk),
		.ctrl    (mac_ctrl),
		.weight  (w_rdata),
		.operand (operand),
		.bias    (b_rdata),
		.act     (act_new)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcnt_q <= mlpcr_pkg::LCNT_RESET;
			thr_q  <= mlpcr_pkg::THR_RESET;
			for (int i = 0; i < ML; i++) begin
				size_q[i] <= mlpcr_pkg::SIZE_RESET;
			end
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.reg_index == mlpcr_pkg::REG_LAYER_COUNT) begin
				lcnt_q <= cfg.wdata[mlpcr_pkg::LCNT_W-1:0];
			end else if (cfg.reg_index >= mlpcr_pkg::REG_SIZE_FIRST
				&& cfg.reg_index <= mlpcr_pkg::REG_SIZE_LAST) begin
				size_q[LW'(cfg.reg_index - mlpcr_pkg::REG_SIZE_FIRST)] <= cfg.wdata[SW-1:0];
			end else if (cfg.reg_index == mlpcr_pkg::REG_THRESHOLD) begin
				thr_q <= cfg.wdata[mlpcr_pkg::THR_W-1:0];
			end
		end
	end

	// input neurons, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MW; i++) begin
				in_q[i] <= '0;
			end
		end else if (cmd_acc && (cmd.command == mlpcr_pkg::CMD_INPUT)) begin
			in_q[cmd.dest_neuron] <= cmd.data_value;
		end
	end

	// activation banks, always written before they are read
	always_ff @(posedge clk) begin
		if (state_q == ST_ACT) begin
			act_q[{l_q[0], d_q}] <= act_new;
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			l_q         <= '0;
			d_q         <= '0;
			s_q         <= '0;
			res_valid_q <= 1'b0;
			res_index_q <= '0;
			res_bit_q   <= 1'b0;
			res_last_q  <= 1'b0;
		end else begin
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc && (cmd.command == mlpcr_pkg::CMD_RUN)) begin
						l_q     <= '0;
						d_q     <= '0;
						s_q     <= '0;
						state_q <= ST_W_RD;
					end
				end
				ST_W_RD: begin
					state_q <= ST_W_MUL;
				end
				ST_W_MUL: begin
					state_q <= ST_W_ACC;
				end
				ST_W_ACC: begin
					if (s_last) begin
						state_q <= ST_B_LD;
					end else begin
						s_q     <= s_q + NW'(1);
						state_q <= ST_W_RD;
					end
				end
				ST_B_LD: begin
					state_q <= ST_B_ACC;
				end
				ST_B_ACC: begin
					state_q <= ST_ACT;
				end
				ST_ACT: begin
					s_q <= '0;
					if (!d_last) begin
						d_q     <= d_q + NW'(1);
						state_q <= ST_W_RD;
					end else if (!l_last) begin
						d_q     <= '0;
						l_q     <= l_q + LW'(1);
						state_q <= ST_W_RD;
					end else begin
						d_q     <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// one output neuron per free slot in the result register
					if (res_free) begin
						res_valid_q <= 1'b1;
						res_index_q <= d_q;
						res_bit_q   <= (act_rd > thr_q);
						res_last_q  <= d_last;
						d_q         <= d_q + NW'(1);
						if (d_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/mlpcr_ram.sv
// mlpcr_ram: generic single write, single read ram with registered read data
// no dependencies

module mlpcr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/mlpcr_mac.sv
// mlpcr_mac: shared multiply, saturating accumulate and relu/clamp unit
// depends on mlpcr_pkg for widths and the mac_ctrl_t control struct

module mlpcr_mac (
	input  logic                                   clk,
	input  mlpcr_pkg::mac_ctrl_t                   ctrl,
	input  logic signed [mlpcr_pkg::VALUE_BITS-1:0] weight,
	input  logic signed [mlpcr_pkg::VALUE_BITS-1:0] operand,
	input  logic signed [mlpcr_pkg::VALUE_BITS-1:0] bias,
	output logic [mlpcr_pkg::ACT_W-1:0]            act
);

	localparam int PW = mlpcr_pkg::PROD_W;
	localparam int AW = mlpcr_pkg::ACC_W;
	localparam int FB = mlpcr_pkg::FRAC_BITS;

	localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
	localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};
	localparam logic signed [AW-1:0] ONE_SQ  = AW'(1) <<< (2 * FB);

	logic signed [PW-1:0] prod_q;
	logic signed [AW-1:0] acc_q;
	logic signed [AW:0]   sum;
	logic signed [AW-1:0] sum_sat;

	// one product or the scaled bias per cycle
	always_ff @(posedge clk) begin
		if (ctrl.mul_weight) begin
			prod_q <= PW'(weight * operand);
		end else if (ctrl.load_bias) begin
			prod_q <= PW'(bias) <<< FB;
		end
	end

	// saturating add on one extra bit
	always_comb begin
		sum = {acc_q[AW-1], acc_q} + (AW+1)'(prod_q);
		if (sum[AW] != sum[AW-1]) begin
			sum_sat = sum[AW] ? ACC_MIN : ACC_MAX;
		end else begin
			sum_sat = sum[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_add) begin
			acc_q <= sum_sat;
		end
	end

	// relu, clamp at one, rescale from 2*FB to FB fraction bits
	always_comb begin
		if (acc_q <= 0) begin
			act = '0;
		end else if (acc_q >= ONE_SQ) begin
			act = mlpcr_pkg::ACT_W'(1) << FB;
		end else begin
			act = {1'b0, acc_q[2*FB-1:FB]};
		end
	end

endmodule

### hw/rtl/mlpcr_checker.sv
// mlpcr_checker: port level checks of the mlp inference unit, bound to the top level
// depends on mlpcr_pkg for command codes

module mlpcr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_valid,
	input logic                          cmd_ready,
	input logic [mlpcr_pkg::CMD_W-1:0]   cmd_command,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [mlpcr_pkg::NIDX_W-1:0]  res_out_index,
	input logic                          res_out_bit,
	input logic                          res_last
);

	logic run_acc;
	logic load_acc;

	assign run_acc  = cmd_valid && cmd_ready && (cmd_command == mlpcr_pkg::CMD_RUN);
	assign load_acc = cmd_valid && cmd_ready && (cmd_command != mlpcr_pkg::CMD_RUN);

	// a run item holds off the next item
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		run_acc |=> !cmd_ready)
		else $error("command channel still ready after a run item");

	// the command channel is ready again in the cycle after a load item
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> cmd_ready)
		else $error("command channel not ready after a load item");

	// nothing follows the final result of a run at once
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && res_last) |=> !res_valid)
		else $error("result item right after the last item of a run");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_out_index)
			&& $stable(res_out_bit) && $stable(res_last)))
		else $error("stalled result item changed");

endmodule

bind mlp_clamped_relu_inference_unit mlpcr_checker u_mlpcr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.cmd_command   (cmd.command),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_out_index (res.out_index),
	.res_out_bit   (res.out_bit),
	.res_last      (res.last)
);
